@@ src/cln_pkg.sv @@
// Shared types and constants of the character LCD nibble sequencer.
package cln_pkg;

	// One command request on the input channel.
	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] byte_value;
		logic [1:0] row;
		logic [5:0] column;
	} cmd_t;

	// One timed pin state on the output channel.
	typedef struct packed {
		logic        reg_select;
		logic        enable;
		logic [3:0]  nibble;
		logic [15:0] hold_us;
		logic        last;
	} phase_t;

	// Delay registers as seen by the sequencer.
	typedef struct packed {
		logic [15:0] standard_delay_us;
		logic [15:0] clear_delay_us;
		logic [15:0] power_up_wait_us;
		logic [15:0] second_wait_us;
		logic [15:0] third_wait_us;
	} cfg_t;

	// Command modes.
	localparam logic [2:0] MODE_INIT   = 3'd0;
	localparam logic [2:0] MODE_DATA   = 3'd1;
	localparam logic [2:0] MODE_CTRL   = 3'd2;
	localparam logic [2:0] MODE_CLEAR  = 3'd3;
	localparam logic [2:0] MODE_CURSOR = 3'd4;

	// Cursor rows that produce writes.
	localparam logic [1:0] ROW_FIRST  = 2'd1;
	localparam logic [1:0] ROW_SECOND = 2'd2;

	// Register map: index taken from paddr[4:2].
	localparam int         PADDR_W      = 5;
	localparam logic [2:0] REG_STANDARD = 3'd0;
	localparam logic [2:0] REG_CLEAR    = 3'd1;
	localparam logic [2:0] REG_POWER_UP = 3'd2;
	localparam logic [2:0] REG_SECOND   = 3'd3;
	localparam logic [2:0] REG_THIRD    = 3'd4;

	// Register reset values.
	localparam logic [15:0] RST_STANDARD = 16'd50;
	localparam logic [15:0] RST_CLEAR    = 16'd1700;
	localparam logic [15:0] RST_POWER_UP = 16'd15000;
	localparam logic [15:0] RST_SECOND   = 16'd4500;
	localparam logic [15:0] RST_THIRD    = 16'd100;

	// Fixed command bytes.
	localparam logic [7:0] CLEAR_BYTE  = 8'h01;
	localparam logic [7:0] CURSOR_BASE = 8'h80;
	localparam logic [7:0] ROW2_OFFSET = 8'h40;

	// Microcode step kinds.
	localparam logic KIND_WAIT = 1'b0;
	localparam logic KIND_NIB  = 1'b1;

	// Nibble sources.
	localparam logic [1:0] NSRC_CONST = 2'd0;
	localparam logic [1:0] NSRC_HI    = 2'd1;
	localparam logic [1:0] NSRC_LO    = 2'd2;

	// Hold time sources.
	localparam logic [2:0] HOLD_STD    = 3'd0;
	localparam logic [2:0] HOLD_CLR    = 3'd1;
	localparam logic [2:0] HOLD_PU     = 3'd2;
	localparam logic [2:0] HOLD_SECOND = 3'd3;
	localparam logic [2:0] HOLD_THIRD  = 3'd4;
	localparam logic [2:0] HOLD_CMD    = 3'd5;

	// Program entry points.
	localparam int             STEP_W     = 5;
	localparam logic [STEP_W-1:0] STEP_INIT = 5'd0;
	localparam logic [STEP_W-1:0] STEP_BYTE = 5'd15;

	// Phase within a nibble write.
	localparam logic [1:0] PH_SETUP = 2'd0;
	localparam logic [1:0] PH_HIGH  = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;

	// One microcode control word.
	typedef struct packed {
		logic       kind;
		logic [1:0] nib_src;
		logic [3:0] const_nib;
		logic [2:0] hold_src;
		logic       stop;
	} ucode_t;

endpackage

@@ src/cln_if.sv @@
// Request channels of the sequencer: commands in, pin phases out.
interface cln_cmd_if;
	logic          valid;
	logic          ready;
	cln_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cln_phase_if;
	logic            valid;
	logic            ready;
	cln_pkg::phase_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/cln_ucode_rom.sv @@
// Microcode program store of the sequencer.
module cln_ucode_rom (
	input  logic [cln_pkg::STEP_W-1:0] step,
	output cln_pkg::ucode_t            uword
);

	// Init runs steps 0 to 14; a single byte runs steps 15 and 16.
	always_comb begin
		unique case (step)
			5'd0:  uword = '{cln_pkg::KIND_WAIT, cln_pkg::NSRC_CONST, 4'h0,
				cln_pkg::HOLD_PU, 1'b0};
			5'd1:  uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h3,
				cln_pkg::HOLD_STD, 1'b0};
			5'd2:  uword = '{cln_pkg::KIND_WAIT, cln_pkg::NSRC_CONST, 4'h0,
				cln_pkg::HOLD_SECOND, 1'b0};
			5'd3:  uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h3,
				cln_pkg::HOLD_STD, 1'b0};
			5'd4:  uword = '{cln_pkg::KIND_WAIT, cln_pkg::NSRC_CONST, 4'h0,
				cln_pkg::HOLD_THIRD, 1'b0};
			5'd5:  uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h3,
				cln_pkg::HOLD_STD, 1'b0};
			5'd6:  uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h2,
				cln_pkg::HOLD_STD, 1'b0};
			5'd7:  uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h2,
				cln_pkg::HOLD_STD, 1'b0};
			5'd8:  uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h8,
				cln_pkg::HOLD_STD, 1'b0};
			5'd9:  uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h0,
				cln_pkg::HOLD_STD, 1'b0};
			5'd10: uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h8,
				cln_pkg::HOLD_STD, 1'b0};
			5'd11: uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h0,
				cln_pkg::HOLD_CLR, 1'b0};
			5'd12: uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h1,
				cln_pkg::HOLD_CLR, 1'b0};
			5'd13: uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h0,
				cln_pkg::HOLD_STD, 1'b0};
			5'd14: uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_CONST, 4'h6,
				cln_pkg::HOLD_STD, 1'b1};
			5'd15: uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_HI, 4'h0,
				cln_pkg::HOLD_CMD, 1'b0};
			5'd16: uword = '{cln_pkg::KIND_NIB, cln_pkg::NSRC_LO, 4'h0,
				cln_pkg::HOLD_CMD, 1'b1};
			// Unused addresses end the program at once.
			default: uword = '{cln_pkg::KIND_WAIT, cln_pkg::NSRC_CONST, 4'h0,
				cln_pkg::HOLD_STD, 1'b1};
		endcase
	end

endmodule

@@ src/cln_cfg_regs.sv @@
// APB-style delay register bank of the sequencer.
module cln_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cln_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output cln_pkg::cfg_t               cfg
);

	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.standard_delay_us <= cln_pkg::RST_STANDARD;
			cfg.clear_delay_us    <= cln_pkg::RST_CLEAR;
			cfg.power_up_wait_us  <= cln_pkg::RST_POWER_UP;
			cfg.second_wait_us    <= cln_pkg::RST_SECOND;
			cfg.third_wait_us     <= cln_pkg::RST_THIRD;
		end else if (wr_en) begin
			unique case (reg_idx)
				cln_pkg::REG_STANDARD: cfg.standard_delay_us <= pwdata[15:0];
				cln_pkg::REG_CLEAR:    cfg.clear_delay_us    <= pwdata[15:0];
				cln_pkg::REG_POWER_UP: cfg.power_up_wait_us  <= pwdata[15:0];
				cln_pkg::REG_SECOND:   cfg.second_wait_us    <= pwdata[15:0];
				cln_pkg::REG_THIRD:    cfg.third_wait_us     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		unique case (reg_idx)
			cln_pkg::REG_STANDARD: prdata = {16'd0, cfg.standard_delay_us};
			cln_pkg::REG_CLEAR:    prdata = {16'd0, cfg.clear_delay_us};
			cln_pkg::REG_POWER_UP: prdata = {16'd0, cfg.power_up_wait_us};
			cln_pkg::REG_SECOND:   prdata = {16'd0, cfg.second_wait_us};
			cln_pkg::REG_THIRD:    prdata = {16'd0, cfg.third_wait_us};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

@@ src/char_lcd_nibble_sequencer.sv @@
// Top level of the character LCD nibble sequencer.
// Each accepted command is expanded by a small microcode program into timed pin
// phases for a 4-bit character LCD: init gives 39 phases, a data, control, clear
// or cursor command gives 6, and an unused mode or a cursor row other than 1 or 2
// gives none. The step counter walks the program store and emits one phase per
// clock, while the output side does not stall, into a single output register;
// a command occupies the block until its final phase has been loaded, and the
// next command is taken only then. Delays are set through the APB-style
// register port.
module char_lcd_nibble_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	cln_cmd_if.sink                     cmd,
	cln_phase_if.source                 phase,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cln_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	cln_pkg::cfg_t                cfg;
	cln_pkg::ucode_t              uword;
	cln_pkg::phase_t              out_q;
	logic                         out_valid_q;
	logic                         busy_q;
	logic [cln_pkg::STEP_W-1:0]   step_q;
	logic [1:0]                   phase_q;
	logic                         held_rs_q;
	logic [3:0]                   held_nib_q;
	logic [7:0]                   byte_q;
	logic                         rs_q;
	logic                         clr_q;
	logic                         accept;
	logic                         adv;
	logic                         step_done;
	logic [3:0]                   new_nib;
	logic [15:0]                  hold;
	logic [7:0]                   cur_addr;

	cln_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cln_ucode_rom u_rom (
		.step  (step_q),
		.uword (uword)
	);

	// Handshakes: a new command only when no program is running.
	assign cmd.ready   = !busy_q;
	assign accept      = cmd.valid && !busy_q;
	assign adv         = busy_q && (!out_valid_q || phase.ready);
	assign phase.valid = out_valid_q;
	assign phase.data  = out_q;

	// Cursor address from the one-based column.
	assign cur_addr = ({2'b00, cmd.data.column} - 8'd1) | cln_pkg::CURSOR_BASE;

	// A wait is one phase; a nibble write finishes on its closing low phase.
	assign step_done = (uword.kind == cln_pkg::KIND_WAIT) || (phase_q == cln_pkg::PH_LOW);

	// Nibble source selection.
	always_comb begin
		unique case (uword.nib_src)
			cln_pkg::NSRC_HI: new_nib = byte_q[7:4];
			cln_pkg::NSRC_LO: new_nib = byte_q[3:0];
			default:          new_nib = uword.const_nib;
		endcase
	end

	// Hold time selection.
	always_comb begin
		unique case (uword.hold_src)
			cln_pkg::HOLD_CLR:    hold = cfg.clear_delay_us;
			cln_pkg::HOLD_PU:     hold = cfg.power_up_wait_us;
			cln_pkg::HOLD_SECOND: hold = cfg.second_wait_us;
			cln_pkg::HOLD_THIRD:  hold = cfg.third_wait_us;
			cln_pkg::HOLD_CMD:    hold = clr_q ? cfg.clear_delay_us : cfg.standard_delay_us;
			default:              hold = cfg.standard_delay_us;
		endcase
	end

	// Command decode, step counter and nibble phase counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= cln_pkg::STEP_INIT;
			phase_q <= cln_pkg::PH_SETUP;
		end else if (accept) begin
			phase_q <= cln_pkg::PH_SETUP;
			priority if (cmd.data.mode == cln_pkg::MODE_INIT) begin
				busy_q <= 1'b1;
				step_q <= cln_pkg::STEP_INIT;
			end else if (cmd.data.mode == cln_pkg::MODE_DATA
				|| cmd.data.mode == cln_pkg::MODE_CTRL
				|| cmd.data.mode == cln_pkg::MODE_CLEAR) begin
				busy_q <= 1'b1;
				step_q <= cln_pkg::STEP_BYTE;
			end else if (cmd.data.mode == cln_pkg::MODE_CURSOR
				&& (cmd.data.row == cln_pkg::ROW_FIRST
				|| cmd.data.row == cln_pkg::ROW_SECOND)) begin
				busy_q <= 1'b1;
				step_q <= cln_pkg::STEP_BYTE;
			end else begin
				busy_q <= 1'b0;
			end
		end else if (adv) begin
			if (step_done) begin
				phase_q <= cln_pkg::PH_SETUP;
				if (uword.stop) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end else begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	// Command operands: byte, register select and delay choice.
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (cmd.data.mode)
				cln_pkg::MODE_DATA: begin
					byte_q <= cmd.data.byte_value;
					rs_q   <= 1'b1;
					clr_q  <= 1'b0;
				end
				cln_pkg::MODE_CLEAR: begin
					byte_q <= cln_pkg::CLEAR_BYTE;
					rs_q   <= 1'b0;
					clr_q  <= 1'b1;
				end
				cln_pkg::MODE_CURSOR: begin
					byte_q <= (cmd.data.row == cln_pkg::ROW_SECOND)
						? (cur_addr | cln_pkg::ROW2_OFFSET) : cur_addr;
					rs_q   <= 1'b0;
					clr_q  <= 1'b0;
				end
				default: begin
					byte_q <= cmd.data.byte_value;
					rs_q   <= 1'b0;
					clr_q  <= 1'b0;
				end
			endcase
		end
	end

	// Pin levels remembered between phases and commands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_rs_q  <= 1'b0;
			held_nib_q <= 4'd0;
		end else if (adv && uword.kind == cln_pkg::KIND_NIB
			&& phase_q == cln_pkg::PH_SETUP) begin
			held_rs_q  <= rs_q;
			held_nib_q <= new_nib;
		end
	end

	// Output register: the setup phase shows the old pins, later phases the new.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (phase.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.reg_select <= held_rs_q;
			out_q.enable     <= (uword.kind == cln_pkg::KIND_NIB)
				&& (phase_q == cln_pkg::PH_HIGH);
			out_q.nibble     <= held_nib_q;
			out_q.hold_us    <= hold;
			out_q.last       <= uword.stop && step_done;
		end
	end

	// A phase with enable high is always followed by its closing low phase.
	a_high_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		phase.valid && phase.data.enable |-> !phase.data.last)
		else $error("enable-high phase marked as last");

	// The nibble phase counter never reaches its unused code.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("nibble phase counter out of range");

	// A new command always starts at the setup phase of a nibble.
	a_start_setup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> phase_q == cln_pkg::PH_SETUP)
		else $error("command accepted in the middle of a nibble");

	// The remembered pins change only when a phase is produced.
	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(held_nib_q) && $stable(held_rs_q))
		else $error("held pins changed without a phase");

endmodule
